>>> src/xfpc_pkg.sv
// ----------------------------------------------------------------------------
// xfpc_pkg
// Shared types and constants of the framed packet checker: beat structs,
// status codes, register map and default limits.
// ----------------------------------------------------------------------------
package xfpc_pkg;

    // default limit on frame size in bytes
    localparam int DEFAULT_MAX_FRAME_BYTES = 32;

    // frame layout constants
    localparam logic [7:0] MIN_FRAME_BYTES  = 8'd5;
    localparam logic [7:0] MIN_LENGTH_FIELD = 8'd2;
    localparam logic [7:0] LENGTH_OVERHEAD  = 8'd3;
    localparam logic [7:0] CMD_OVERHEAD     = 8'd2;
    localparam logic [7:0] MIN_THROTTLE_LEN = 8'd3;

    // byte positions inside a frame
    localparam logic [7:0] POS_HEAD    = 8'd0;
    localparam logic [7:0] POS_LENGTH  = 8'd1;
    localparam logic [7:0] POS_COMMAND = 8'd2;
    localparam logic [7:0] POS_PAYLOAD = 8'd3;
    localparam logic [7:0] POS_PAYLOAD_END = 8'd5;

    // register map
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_HEAD_BYTE     = 2'd0,
        REG_TAIL_BYTE     = 2'd1,
        REG_THROTTLE_CODE = 2'd2,
        REG_UNUSED        = 2'd3
    } reg_index_t;

    localparam logic [7:0] RESET_HEAD_BYTE     = 8'd170;
    localparam logic [7:0] RESET_TAIL_BYTE     = 8'd187;
    localparam logic [7:0] RESET_THROTTLE_CODE = 8'd17;

    // frame status codes
    typedef enum logic [2:0] {
        STATUS_OK         = 3'd0,
        STATUS_SHORT      = 3'd1,
        STATUS_BAD_EDGE   = 3'd2,
        STATUS_BAD_LENGTH = 3'd3,
        STATUS_BAD_XOR    = 3'd4,
        STATUS_OVERLONG   = 3'd5
    } frame_status_t;

    // configuration seen by the datapath
    typedef struct packed {
        logic [7:0] head_byte;
        logic [7:0] tail_byte;
        logic [7:0] throttle_code;
    } cfg_t;

    // one input beat
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_packet;
    } in_beat_t;

    // one result beat
    typedef struct packed {
        logic [2:0] frame_status;
        logic [7:0] command;
        logic [7:0] payload_count;
        logic       throttle_valid;
        logic [7:0] steer_value;
        logic [7:0] thrust_value;
        logic [7:0] button_value;
    } result_t;

endpackage

>>> src/xfpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// xfpc_cfg_regs
// APB-style register block holding head byte, tail byte and throttle code.
// ----------------------------------------------------------------------------
module xfpc_cfg_regs
    import xfpc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    reg_index_t reg_sel;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_sel = reg_index_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.head_byte     <= RESET_HEAD_BYTE;
            cfg_reg.tail_byte     <= RESET_TAIL_BYTE;
            cfg_reg.throttle_code <= RESET_THROTTLE_CODE;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_HEAD_BYTE:     cfg_reg.head_byte     <= pwdata[7:0];
                REG_TAIL_BYTE:     cfg_reg.tail_byte     <= pwdata[7:0];
                REG_THROTTLE_CODE: cfg_reg.throttle_code <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            REG_HEAD_BYTE:     prdata[7:0] = cfg_reg.head_byte;
            REG_TAIL_BYTE:     prdata[7:0] = cfg_reg.tail_byte;
            REG_THROTTLE_CODE: prdata[7:0] = cfg_reg.throttle_code;
            default:           prdata      = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

>>> src/xfpc_frame_track.sv
// ----------------------------------------------------------------------------
// xfpc_frame_track
// Per-packet state (position, header fields, running xor, payload head) and
// the status decision made on the last byte of a packet.
// ----------------------------------------------------------------------------
module xfpc_frame_track
    import xfpc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     step,
    input  in_beat_t beat,
    input  cfg_t     cfg,
    output result_t  result
);

    localparam logic [7:0] MaxIdx = 8'(MAX_FRAME_BYTES);

    logic [7:0] idx_reg,   idx_next;
    logic [7:0] first_reg, first_next;
    logic [7:0] len_reg,   len_next;
    logic [7:0] cmd_reg,   cmd_next;
    logic [7:0] xor_reg,   xor_next;
    logic [7:0] prev_reg,  prev_next;
    logic [7:0] ph_reg  [3];
    logic [7:0] ph_next [3];
    logic       over_reg,  over_next;

    logic          in_range;
    logic [7:0]    b;
    logic [7:0]    calc;
    logic [7:0]    plen;
    logic [1:0]    ph_sel;
    frame_status_t status;

    assign b        = beat.rx_byte;
    assign in_range = idx_reg < MaxIdx;
    assign ph_sel   = 2'(idx_reg - POS_PAYLOAD);

    // state update for this byte
    always_comb begin
        idx_next   = idx_reg;
        first_next = first_reg;
        len_next   = len_reg;
        cmd_next   = cmd_reg;
        xor_next   = xor_reg;
        prev_next  = prev_reg;
        ph_next    = ph_reg;
        over_next  = over_reg;
        if (!in_range) begin
            over_next = 1'b1;
        end else begin
            if (idx_reg == POS_HEAD) begin
                first_next = b;
            end else begin
                xor_next = xor_reg ^ b;
            end
            if (idx_reg == POS_LENGTH) begin
                len_next = b;
            end else if (idx_reg == POS_COMMAND) begin
                cmd_next = b;
            end else if (idx_reg >= POS_PAYLOAD && idx_reg <= POS_PAYLOAD_END) begin
                ph_next[ph_sel] = b;
            end
            if (!beat.end_of_packet) begin
                prev_next = b;
            end
            if (idx_reg != 8'hFF) begin
                idx_next = idx_reg + 8'd1;
            end
        end
    end

    // status decision, overlong first
    assign calc = xor_next ^ prev_next ^ b;
    assign plen = len_next - CMD_OVERHEAD;

    always_comb begin
        priority if (over_next) begin
            status = STATUS_OVERLONG;
        end else if (idx_next < MIN_FRAME_BYTES) begin
            status = STATUS_SHORT;
        end else if (first_next != cfg.head_byte || b != cfg.tail_byte) begin
            status = STATUS_BAD_EDGE;
        end else if (len_next < MIN_LENGTH_FIELD ||
                     (len_next + LENGTH_OVERHEAD) != idx_next) begin
            status = STATUS_BAD_LENGTH;
        end else if (calc != prev_next) begin
            status = STATUS_BAD_XOR;
        end else begin
            status = STATUS_OK;
        end
    end

    // result fields, zero where the frame failed
    always_comb begin
        result              = '0;
        result.frame_status = status;
        if (status == STATUS_OK) begin
            result.command       = cmd_next;
            result.payload_count = plen;
            if (cmd_next == cfg.throttle_code && plen >= MIN_THROTTLE_LEN) begin
                result.throttle_valid = 1'b1;
                result.steer_value    = ph_next[0];
                result.thrust_value   = ph_next[1];
                result.button_value   = ph_next[2];
            end
        end
    end

    // packet state, cleared after the last byte
    always_ff @(posedge aclk) begin
        if (!aresetn || (step && beat.end_of_packet)) begin
            idx_reg   <= '0;
            first_reg <= '0;
            len_reg   <= '0;
            cmd_reg   <= '0;
            xor_reg   <= '0;
            prev_reg  <= '0;
            ph_reg    <= '{default: '0};
            over_reg  <= 1'b0;
        end else if (step) begin
            idx_reg   <= idx_next;
            first_reg <= first_next;
            len_reg   <= len_next;
            cmd_reg   <= cmd_next;
            xor_reg   <= xor_next;
            prev_reg  <= prev_next;
            ph_reg    <= ph_next;
            over_reg  <= over_next;
        end
    end

endmodule

>>> src/xor_framed_packet_checker.sv
// ----------------------------------------------------------------------------
// xor_framed_packet_checker
// Checks HEAD | LEN | CMD | payload | XOR | TAIL frames arriving one byte per
// beat and reports one status beat per packet on its last byte.
// ----------------------------------------------------------------------------
//  channel   ports                        carries
//  s_        s_valid s_ready s_data       rx byte and end-of-packet flag
//  m_        m_valid m_ready m_data       status, command, throttle values
//  apb       psel penable pwrite paddr    head, tail, throttle code
//
//  one byte is taken per clock unless a last byte waits for a full result;
//  m_valid rises once the input register, then the result register, take it.
//  aresetn is synchronous and active low; it clears the packet state and
//  restores register defaults.
//  a stalled result beat holds only bytes that end a packet; other bytes
//  keep flowing while m_ready is low, until a packet's last byte waits.
// ----------------------------------------------------------------------------
module xor_framed_packet_checker
    import xfpc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_beat_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output result_t               m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t     cfg;
    logic     in_valid_reg;
    in_beat_t in_beat_reg;
    logic     out_valid_reg;
    result_t  out_data_reg;
    result_t  result;
    logic     advance;

    xfpc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    xfpc_frame_track #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .beat    (in_beat_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // a held byte moves on unless it needs a result slot that is full and not draining
    assign advance = in_valid_reg &&
                     (!in_beat_reg.end_of_packet || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_beat_reg <= s_data;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_beat_reg.end_of_packet) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_beat_reg.end_of_packet) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
